>>> design/gcsm_pkg.sv
package gcsm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_RICE_P        = 2'd0;
    localparam logic [1:0] CFG_ELEMENT_COUNT = 2'd1;
    localparam logic [1:0] CFG_TARGET_VALUE  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [5:0]  RICE_P_RESET        = 6'd19;
    localparam logic [31:0] ELEMENT_COUNT_RESET = 32'd0;
    localparam logic [63:0] TARGET_VALUE_RESET  = 64'd0;

    // Outcome codes of a result word
    localparam logic [1:0] OUTCOME_FOUND  = 2'd0;
    localparam logic [1:0] OUTCOME_PASSED = 2'd1;
    localparam logic [1:0] OUTCOME_ALL    = 2'd2;
    localparam logic [1:0] OUTCOME_ENDED  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load_byte;    // capture the accepted input word
        logic       bit_step;     // decode the next stream bit
        logic       flush_start;  // open a zero-filled remainder at stream end
        logic       flush_step;   // shift one zero bit into the delta
        logic       add;          // add the finished delta to the running sum
        logic       rearm;        // clear decode state for the next stream
        logic       emit;         // load the result register
        logic       emit_match;
        logic [1:0] emit_code;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cur_bit;      // stream bit decoded next
        logic last;         // captured word closes the stream
        logic in_rem;       // decoding a remainder
        logic left_one;     // one remainder bit left
        logic p_zero;       // rice_p is zero
        logic count_empty;  // element_count is zero
        logic delta_zero;   // quotient or delta register is zero
        logic seen_zero;    // no value decoded yet
        logic sum_eq;       // running sum equals the target
        logic sum_gt;       // running sum is above the target
        logic seen_all;     // decoded count reached element_count
        logic out_busy;     // result register holds a word not yet taken
    } t_status;

endpackage

>>> design/gcsm_datapath.sv
module gcsm_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic [7:0]         i_stream_byte,
    input  logic               i_last_byte,
    input  logic               i_ready,
    input  gcsm_pkg::t_cmd     i_cmd,
    output gcsm_pkg::t_status  o_status,
    output logic               o_valid,
    output logic               o_matched,
    output logic [1:0]         o_outcome,
    output logic [31:0]        o_values_seen
);

    // Configuration registers
    logic [5:0]  r_rice_p;
    logic [31:0] r_element_count;
    logic [63:0] r_target_value;

    // Decode state
    logic [7:0]  r_byte;
    logic        r_last;
    logic [63:0] r_delta;   // quotient count, then delta as remainder bits shift in
    logic [63:0] r_sum;
    logic [5:0]  r_left;
    logic        r_in_rem;
    logic [31:0] r_seen;

    // Result register
    logic        r_out_valid;
    logic        r_out_match;
    logic [1:0]  r_out_code;
    logic [31:0] r_out_seen;

    logic        w_bit;

    assign w_bit = r_byte[7];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rice_p        <= gcsm_pkg::RICE_P_RESET;
            r_element_count <= gcsm_pkg::ELEMENT_COUNT_RESET;
            r_target_value  <= gcsm_pkg::TARGET_VALUE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gcsm_pkg::CFG_RICE_P:        r_rice_p        <= i_cfg_data[5:0];
                gcsm_pkg::CFG_ELEMENT_COUNT: r_element_count <= i_cfg_data[31:0];
                gcsm_pkg::CFG_TARGET_VALUE:  r_target_value  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the input word and shift out one bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_stream_byte;
            r_last <= i_last_byte;
        end else if (i_cmd.bit_step) begin
            r_byte <= {r_byte[6:0], 1'b0};
        end
    end

    // Decode quotient and remainder, accumulate the sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.rearm) begin
            r_delta  <= '0;
            r_sum    <= '0;
            r_left   <= '0;
            r_in_rem <= 1'b0;
            r_seen   <= '0;
        end else if (i_cmd.add) begin
            r_sum    <= r_sum + r_delta;
            r_seen   <= r_seen + 32'd1;
            r_delta  <= '0;
            r_left   <= '0;
            r_in_rem <= 1'b0;
        end else if (i_cmd.bit_step) begin
            if (!r_in_rem) begin
                if (w_bit) begin
                    r_delta <= r_delta + 64'd1;
                end else if (r_rice_p != 6'd0) begin
                    r_in_rem <= 1'b1;
                    r_left   <= r_rice_p;
                end
            end else begin
                r_delta <= {r_delta[62:0], w_bit};
                r_left  <= r_left - 6'd1;
            end
        end else if (i_cmd.flush_start) begin
            r_in_rem <= 1'b1;
            r_left   <= r_rice_p;
        end else if (i_cmd.flush_step) begin
            r_delta <= {r_delta[62:0], 1'b0};
            r_left  <= r_left - 6'd1;
        end
    end

    // Hold a result word until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_match <= i_cmd.emit_match;
            r_out_code  <= i_cmd.emit_code;
            r_out_seen  <= r_seen;
        end
    end

    // Report status
    always_comb begin
        o_status.cur_bit     = w_bit;
        o_status.last        = r_last;
        o_status.in_rem      = r_in_rem;
        o_status.left_one    = (r_left == 6'd1);
        o_status.p_zero      = (r_rice_p == 6'd0);
        o_status.count_empty = (r_element_count == 32'd0);
        o_status.delta_zero  = (r_delta == 64'd0);
        o_status.seen_zero   = (r_seen == 32'd0);
        o_status.sum_eq      = (r_sum == r_target_value);
        o_status.sum_gt      = (r_sum > r_target_value);
        o_status.seen_all    = (r_seen == r_element_count);
        o_status.out_busy    = r_out_valid && !i_ready;
    end

    assign o_valid       = r_out_valid;
    assign o_matched     = r_out_match;
    assign o_outcome     = r_out_code;
    assign o_values_seen = r_out_seen;

endmodule

>>> design/gcsm_controller.sv
module gcsm_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gcsm_pkg::t_status  i_status,
    output gcsm_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BITS,
        ST_ADD,
        ST_CMP,
        ST_EMIT,
        ST_END,
        ST_FLUSH
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_bits_left, n_bits_left;
    logic        r_decided, n_decided;
    logic        r_flush, n_flush;
    logic        r_emit_match, n_emit_match;
    logic [1:0]  r_emit_code, n_emit_code;

    logic        w_finish;
    logic        w_pending;

    // A value completes on a closing zero with no remainder, or on its last remainder bit
    assign w_finish = (!i_status.in_rem && !i_status.cur_bit && i_status.p_zero) ||
                      (i_status.in_rem && i_status.left_one);

    // A partly decoded value, or none at all, is completed with zeros at stream end
    assign w_pending = i_status.in_rem || !i_status.delta_zero || i_status.seen_zero;

    assign o_ready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_bits_left  = r_bits_left;
        n_decided    = r_decided;
        n_flush      = r_flush;
        n_emit_match = r_emit_match;
        n_emit_code  = r_emit_code;
        o_cmd        = '0;
        o_cmd.emit_match = r_emit_match;
        o_cmd.emit_code  = r_emit_code;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_byte = 1'b1;
                    n_bits_left     = 4'd8;
                    if (r_decided) begin
                        n_state = ST_END;
                    end else if (i_status.count_empty) begin
                        n_emit_match = 1'b0;
                        n_emit_code  = gcsm_pkg::OUTCOME_ENDED;
                        n_state      = ST_EMIT;
                    end else begin
                        n_state = ST_BITS;
                    end
                end
            end
            ST_BITS: begin
                o_cmd.bit_step = 1'b1;
                n_bits_left    = r_bits_left - 4'd1;
                if (w_finish) begin
                    n_state = ST_ADD;
                end else if (r_bits_left == 4'd1) begin
                    n_state = ST_END;
                end
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                n_emit_match = 1'b0;
                if (i_status.sum_eq) begin
                    n_emit_match = 1'b1;
                    n_emit_code  = gcsm_pkg::OUTCOME_FOUND;
                    n_state      = ST_EMIT;
                end else if (i_status.sum_gt) begin
                    n_emit_code = gcsm_pkg::OUTCOME_PASSED;
                    n_state     = ST_EMIT;
                end else if (i_status.seen_all) begin
                    n_emit_code = gcsm_pkg::OUTCOME_ALL;
                    n_state     = ST_EMIT;
                end else if (r_flush) begin
                    n_emit_code = gcsm_pkg::OUTCOME_ENDED;
                    n_state     = ST_EMIT;
                end else if (r_bits_left != 4'd0) begin
                    n_state = ST_BITS;
                end else begin
                    n_state = ST_END;
                end
            end
            ST_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_decided  = 1'b1;
                    n_state    = ST_END;
                end
            end
            ST_END: begin
                if (!i_status.last) begin
                    n_state = ST_IDLE;
                end else if (r_decided) begin
                    o_cmd.rearm = 1'b1;
                    n_decided   = 1'b0;
                    n_flush     = 1'b0;
                    n_state     = ST_IDLE;
                end else if (w_pending) begin
                    n_flush = 1'b1;
                    if (i_status.in_rem) begin
                        n_state = ST_FLUSH;
                    end else if (i_status.p_zero) begin
                        n_state = ST_ADD;
                    end else begin
                        o_cmd.flush_start = 1'b1;
                        n_state           = ST_FLUSH;
                    end
                end else begin
                    n_emit_match = 1'b0;
                    n_emit_code  = gcsm_pkg::OUTCOME_ENDED;
                    n_state      = ST_EMIT;
                end
            end
            ST_FLUSH: begin
                o_cmd.flush_step = 1'b1;
                if (i_status.left_one) begin
                    n_state = ST_ADD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_bits_left  <= '0;
            r_decided    <= 1'b0;
            r_flush      <= 1'b0;
            r_emit_match <= 1'b0;
            r_emit_code  <= gcsm_pkg::OUTCOME_FOUND;
        end else begin
            r_state      <= n_state;
            r_bits_left  <= n_bits_left;
            r_decided    <= n_decided;
            r_flush      <= n_flush;
            r_emit_match <= n_emit_match;
            r_emit_code  <= n_emit_code;
        end
    end

endmodule

>>> design/golomb_rice_set_membership_match_unit.sv
// Golomb-Rice coded set match: feed the set body one byte word at a time, MSB first,
// with i_last_byte on the final word of a stream; the unit returns at most one result
// word per stream (found, passed target, all values decoded, or stream ended / empty
// set) and rearms after the last word. Decoding is bit-serial: each input word is accepted,
// its bits are decoded one at a time, and the word is closed; every completed value adds
// a sum update, then a compare, and loading a result is a step of its own. Once a stream
// is decided, its remaining words are accepted and closed without decoding, and an empty
// set answers without decoding. At the end of a stream an unfinished value is zero-filled
// one bit per cycle, up to rice_p zero bits. A result is held in an output register,
// and the unit stalls only if a new result is due while the previous one is still untaken.
// Write configuration only while the unit is idle between streams.
module golomb_rice_set_membership_match_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input words
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_last_byte,
    // result words
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_matched,
    output logic [1:0]  o_outcome,
    output logic [31:0] o_values_seen
);

    gcsm_pkg::t_cmd    w_cmd;
    gcsm_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    gcsm_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    gcsm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_stream_byte (i_stream_byte),
        .i_last_byte   (i_last_byte),
        .i_ready       (i_ready),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_matched     (o_matched),
        .o_outcome     (o_outcome),
        .o_values_seen (o_values_seen)
    );

endmodule
